FILE: rtl/pvcm_pkg.sv
`default_nettype none
package pvcm_pkg;

    localparam int NUM_SRC   = 3;
    localparam int VEL_W     = 16;
    localparam int AGE_W     = 16;
    localparam int PERIOD_W  = 10;
    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NAV    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TELEOP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_AVOID  = 2'd3;

    localparam logic [SLOT_W-1:0] SLOT_AVOID  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_TELEOP = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_NAV    = 2'd2;

    localparam logic [1:0] SRC_NONE   = 2'd0;
    localparam logic [1:0] SRC_AVOID  = 2'd1;
    localparam logic [1:0] SRC_TELEOP = 2'd2;
    localparam logic [1:0] SRC_NAV    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_AVOID_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TELEOP_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NAV_TIMEOUT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLISH_PERIOD = 2'd3;

    localparam logic [AGE_W-1:0]    AVOID_TIMEOUT_RST  = 16'd250;
    localparam logic [AGE_W-1:0]    TELEOP_TIMEOUT_RST = 16'd500;
    localparam logic [AGE_W-1:0]    NAV_TIMEOUT_RST    = 16'd500;
    localparam logic [PERIOD_W-1:0] PUBLISH_PERIOD_RST = 10'd50;

    typedef struct packed {
        logic signed [VEL_W-1:0] linear_x;
        logic signed [VEL_W-1:0] linear_y;
        logic signed [VEL_W-1:0] linear_z;
        logic signed [VEL_W-1:0] angular_x;
        logic signed [VEL_W-1:0] angular_y;
        logic signed [VEL_W-1:0] angular_z;
    } vel_t;

    typedef struct packed {
        logic [1:0] source;
        vel_t       vel;
    } result_t;

    typedef struct packed {
        logic              upd;
        logic              tick;
        logic [SLOT_W-1:0] slot;
    } bank_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/pvcm_src_bank.sv
`default_nettype none
module pvcm_src_bank
    import pvcm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bank_ctrl_t       ctrl,
    input  wire vel_t             upd_vel,
    input  wire logic [AGE_W-1:0] timeout [NUM_SRC],
    output logic [NUM_SRC-1:0]    fresh_after_tick,
    output vel_t                  cached_vel [NUM_SRC]
);

    vel_t               cache_reg [NUM_SRC];
    logic [NUM_SRC-1:0] received_reg;
    logic [AGE_W-1:0]   age_reg [NUM_SRC];
    logic [AGE_W-1:0]   age_inc [NUM_SRC];

    always_comb
    begin
        for (int s = 0; s < NUM_SRC; s++)
        begin
            age_inc[s] = (age_reg[s] == AGE_MAX) ? age_reg[s] : age_reg[s] + 1'b1;
            fresh_after_tick[s] = received_reg[s] && (age_inc[s] <= timeout[s]);
            cached_vel[s] = cache_reg[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.upd)
        begin
            cache_reg[ctrl.slot] <= upd_vel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            received_reg <= '0;
            for (int s = 0; s < NUM_SRC; s++)
            begin
                age_reg[s] <= '0;
            end
        end
        else if (ctrl.upd)
        begin
            received_reg[ctrl.slot] <= 1'b1;
            age_reg[ctrl.slot]      <= '0;
        end
        else if (ctrl.tick)
        begin
            for (int s = 0; s < NUM_SRC; s++)
            begin
                age_reg[s] <= age_inc[s];
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/pvcm_out_buf.sv
`default_nettype none
module pvcm_out_buf
    import pvcm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         can_push,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop && skid_valid_reg)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !main_valid_reg)
        begin
            main_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            main_data_reg <= skid_data_reg;
        end
        else if (pop || !main_valid_reg)
        begin
            main_data_reg <= push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/priority_velocity_command_mux_unit.sv
// A tick beat that publishes registers its result in the two-entry output buffer, which
// decouples the sides. One input beat is taken per cycle while input ready is high.
// Input ready drops only while both output entries hold results.
// Reset clears ages, received flags, the period count, the stop flag and the buffer,
// and loads the default timeouts and publish period; cached velocities are not reset.
`default_nettype none
module priority_velocity_command_mux_unit
    import pvcm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [CMD_W-1:0]        command,
    input  wire logic signed [VEL_W-1:0] linear_x,
    input  wire logic signed [VEL_W-1:0] linear_y,
    input  wire logic signed [VEL_W-1:0] linear_z,
    input  wire logic signed [VEL_W-1:0] angular_x,
    input  wire logic signed [VEL_W-1:0] angular_y,
    input  wire logic signed [VEL_W-1:0] angular_z,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [1:0]                   selected_source,
    output logic signed [VEL_W-1:0]      out_linear_x,
    output logic signed [VEL_W-1:0]      out_linear_y,
    output logic signed [VEL_W-1:0]      out_linear_z,
    output logic signed [VEL_W-1:0]      out_angular_x,
    output logic signed [VEL_W-1:0]      out_angular_y,
    output logic signed [VEL_W-1:0]      out_angular_z
);

    logic [AGE_W-1:0]    timeout_reg [NUM_SRC];
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] period_count_reg;
    logic [PERIOD_W-1:0] period_count_next;
    logic                stop_sent_reg;
    logic                stop_sent_next;

    logic                accept;
    logic                is_tick;
    logic [PERIOD_W-1:0] count_inc;
    logic [PERIOD_W-1:0] period_eff;
    logic                select_now;
    logic                any_fresh;
    logic                emit;
    bank_ctrl_t          bank_ctrl;
    vel_t                in_vel;
    logic [NUM_SRC-1:0]  fresh;
    vel_t                cached_vel [NUM_SRC];
    result_t             result;
    result_t             out_res;

    assign accept  = in_valid && in_ready;
    assign is_tick = (command == CMD_TICK);

    assign in_vel.linear_x  = linear_x;
    assign in_vel.linear_y  = linear_y;
    assign in_vel.linear_z  = linear_z;
    assign in_vel.angular_x = angular_x;
    assign in_vel.angular_y = angular_y;
    assign in_vel.angular_z = angular_z;

    always_comb
    begin
        bank_ctrl.upd  = accept && !is_tick;
        bank_ctrl.tick = accept && is_tick;
        case (command)
            CMD_AVOID:  bank_ctrl.slot = SLOT_AVOID;
            CMD_TELEOP: bank_ctrl.slot = SLOT_TELEOP;
            default:    bank_ctrl.slot = SLOT_NAV;
        endcase
    end

    pvcm_src_bank u_bank (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (bank_ctrl),
        .upd_vel          (in_vel),
        .timeout          (timeout_reg),
        .fresh_after_tick (fresh),
        .cached_vel       (cached_vel)
    );

    always_comb
    begin
        count_inc  = period_count_reg + 1'b1;
        period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
        select_now = is_tick && ((count_inc == '0) || (count_inc >= period_eff));
        any_fresh  = |fresh;
        emit       = accept && select_now && (any_fresh || !stop_sent_reg);

        period_count_next = period_count_reg;
        stop_sent_next    = stop_sent_reg;
        if (accept && is_tick)
        begin
            period_count_next = select_now ? '0 : count_inc;
            if (select_now)
            begin
                stop_sent_next = !any_fresh;
            end
        end

        if (fresh[SLOT_AVOID])
        begin
            result.source = SRC_AVOID;
            result.vel    = cached_vel[SLOT_AVOID];
        end
        else if (fresh[SLOT_TELEOP])
        begin
            result.source = SRC_TELEOP;
            result.vel    = cached_vel[SLOT_TELEOP];
        end
        else if (fresh[SLOT_NAV])
        begin
            result.source = SRC_NAV;
            result.vel    = cached_vel[SLOT_NAV];
        end
        else
        begin
            result.source = SRC_NONE;
            result.vel    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg[SLOT_AVOID]  <= AVOID_TIMEOUT_RST;
            timeout_reg[SLOT_TELEOP] <= TELEOP_TIMEOUT_RST;
            timeout_reg[SLOT_NAV]    <= NAV_TIMEOUT_RST;
            period_reg               <= PUBLISH_PERIOD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_AVOID_TIMEOUT:  timeout_reg[SLOT_AVOID]  <= cfg_data;
                REG_TELEOP_TIMEOUT: timeout_reg[SLOT_TELEOP] <= cfg_data;
                REG_NAV_TIMEOUT:    timeout_reg[SLOT_NAV]    <= cfg_data;
                REG_PUBLISH_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg <= '0;
            stop_sent_reg    <= 1'b0;
        end
        else
        begin
            period_count_reg <= period_count_next;
            stop_sent_reg    <= stop_sent_next;
        end
    end

    pvcm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (result),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res)
    );

    assign selected_source = out_res.source;
    assign out_linear_x    = out_res.vel.linear_x;
    assign out_linear_y    = out_res.vel.linear_y;
    assign out_linear_z    = out_res.vel.linear_z;
    assign out_angular_x   = out_res.vel.angular_x;
    assign out_angular_y   = out_res.vel.angular_y;
    assign out_angular_z   = out_res.vel.angular_z;

endmodule
`default_nettype wire
